FILE: design/pcs_pkg.sv
// shared widths, command and status codes, and the waiter entry type
package pcs_pkg;

    localparam int WaiterSlotsDefault = 16;

    localparam int CmdW      = 2;
    localparam int IdW       = 8;
    localparam int PrioW     = 8;
    localparam int CountW    = 16;
    localparam int StatusW   = 3;
    localparam int WaitersW  = 5;
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    localparam logic [CmdW-1:0] CMD_WAIT     = 2'd0;
    localparam logic [CmdW-1:0] CMD_POLL     = 2'd1;
    localparam logic [CmdW-1:0] CMD_POST     = 2'd2;

    localparam logic [StatusW-1:0] STAT_ACQUIRED    = 3'd0;
    localparam logic [StatusW-1:0] STAT_QUEUED      = 3'd1;
    localparam logic [StatusW-1:0] STAT_WOULD_BLOCK = 3'd2;
    localparam logic [StatusW-1:0] STAT_FULL        = 3'd3;
    localparam logic [StatusW-1:0] STAT_COUNTED     = 3'd4;
    localparam logic [StatusW-1:0] STAT_WOKE        = 3'd5;
    localparam logic [StatusW-1:0] STAT_SATURATED   = 3'd6;

    localparam logic REG_INITIAL_COUNT = 1'b0;
    localparam logic REG_MAX_COUNT     = 1'b1;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } pcs_entry_t;

endpackage

FILE: design/pcs_waiter_mem.sv
// waiter table storage: one write port, one registered read port
module pcs_waiter_mem
    import pcs_pkg::*;
#(
    parameter int WAITER_SLOTS = WaiterSlotsDefault,
    localparam int IdxW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1
)
(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [IdxW-1:0] wr_addr,
    input  pcs_entry_t      wr_data,
    input  logic [IdxW-1:0] rd_addr,
    output pcs_entry_t      rd_data
);

    pcs_entry_t mem [WAITER_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/priority_counting_semaphore_top.sv
// counting semaphore with a priority waiter table, apb registers and command port
//
//   channel   handshake               payload
//   apb       psel/penable/pwrite     paddr, pwdata -> prdata (pready tied high)
//   command   start & !busy           cmd, task_id, task_priority
//   result    done (one cycle)        status, woken_valid, woken_task, count_now,
//                                     waiters_now
//
// wait, poll, unused codes and a post with no waiters: result in the cycle after the
// transfer, busy stays low so the next command can be taken in that cycle
// post with waiters: busy through the scan and drain states, result registered from drain;
// the single table read port scans one entry a cycle; drain then moves the last entry
// reset clears count, waiter total and sequencer; the table itself holds no reset
// results cannot be stalled: done is high for exactly one cycle per command
module priority_counting_semaphore_top
    import pcs_pkg::*;
#(
    parameter int WAITER_SLOTS = WaiterSlotsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [DataW-1:0]    pwdata,
    output logic [DataW-1:0]    prdata,
    output logic                pready,

    input  logic                start,
    output logic                busy,
    input  logic [CmdW-1:0]     cmd,
    input  logic [IdW-1:0]      task_id,
    input  logic [PrioW-1:0]    task_priority,

    output logic                done,
    output logic [StatusW-1:0]  status,
    output logic                woken_valid,
    output logic [IdW-1:0]      woken_task,
    output logic [CountW-1:0]   count_now,
    output logic [WaitersW-1:0] waiters_now
);

    localparam int IdxW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int TotW = $clog2(WAITER_SLOTS + 1);
    localparam logic [TotW-1:0] SlotsTot = TotW'(WAITER_SLOTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CountW-1:0]   init_reg;
    logic [CountW-1:0]   max_reg;
    logic [CountW-1:0]   count_reg, count_next;
    logic [TotW-1:0]     total_reg, total_next;
    logic [IdxW-1:0]     scan_reg, scan_next;
    logic                rd_vld_reg;
    logic [IdxW-1:0]     rd_idx_reg;
    logic [IdxW-1:0]     best_idx_reg;
    logic [IdW-1:0]      best_id_reg;
    logic [PrioW-1:0]    best_prio_reg;

    logic                done_reg;
    logic [StatusW-1:0]  status_reg;
    logic                woken_valid_reg;
    logic [IdW-1:0]      woken_task_reg;
    logic [CountW-1:0]   count_out_reg;
    logic [WaitersW-1:0] waiters_out_reg;

    logic                accept;
    logic                cfg_wr;
    logic [TotW-1:0]     total_dec;
    logic [IdxW-1:0]     last_idx;
    logic                rd_better;
    logic [IdxW-1:0]     cand_idx;
    logic [IdW-1:0]      cand_id;
    logic [PrioW-1:0]    cand_prio;
    logic                emit;
    logic [StatusW-1:0]  res_status;
    logic                res_woke;
    logic [IdW-1:0]      res_task;
    logic                wr_en;
    logic [IdxW-1:0]     wr_addr;
    pcs_entry_t          wr_data;
    pcs_entry_t          rd_data;

    pcs_waiter_mem #(
        .WAITER_SLOTS (WAITER_SLOTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (scan_reg),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    assign prdata = (paddr[2] == REG_MAX_COUNT) ? {{(DataW-CountW){1'b0}}, max_reg}
                                                : {{(DataW-CountW){1'b0}}, init_reg};

    assign total_dec = total_reg - TotW'(1);
    assign last_idx  = total_dec[IdxW-1:0];

    // entry 0 seeds the running best; later entries win only on strictly higher priority
    assign rd_better = (rd_idx_reg == '0) || (rd_data.prio > best_prio_reg);
    assign cand_idx  = rd_better ? rd_idx_reg   : best_idx_reg;
    assign cand_id   = rd_better ? rd_data.id   : best_id_reg;
    assign cand_prio = rd_better ? rd_data.prio : best_prio_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        scan_next  = scan_reg;
        emit       = 1'b0;
        res_status = STAT_WOULD_BLOCK;
        res_woke   = 1'b0;
        res_task   = '0;
        wr_en      = 1'b0;
        wr_addr    = total_reg[IdxW-1:0];
        wr_data    = '{id: task_id, prio: task_priority};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_WAIT:
                        begin
                            emit = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CountW'(1);
                                res_status = STAT_ACQUIRED;
                            end
                            else if (total_reg >= SlotsTot)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                total_next = total_reg + TotW'(1);
                                res_status = STAT_QUEUED;
                            end
                        end
                        CMD_POLL:
                        begin
                            emit = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CountW'(1);
                                res_status = STAT_ACQUIRED;
                            end
                        end
                        CMD_POST:
                        begin
                            if (total_reg != '0)
                            begin
                                state_next = ST_SCAN;
                                scan_next  = '0;
                            end
                            else if (count_reg < max_reg)
                            begin
                                emit       = 1'b1;
                                count_next = count_reg + CountW'(1);
                                res_status = STAT_COUNTED;
                            end
                            else
                            begin
                                emit       = 1'b1;
                                res_status = STAT_SATURATED;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + IdxW'(1);
                if (scan_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // read data now holds the last entry: move it into the winner's slot
                wr_en      = 1'b1;
                wr_addr    = cand_idx;
                wr_data    = rd_data;
                total_next = total_dec;
                emit       = 1'b1;
                res_status = STAT_WOKE;
                res_woke   = 1'b1;
                res_task   = cand_id;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr && (paddr[2] == REG_INITIAL_COUNT))
        begin
            count_next = pwdata[CountW-1:0];
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            init_reg   <= '0;
            max_reg    <= '1;
            count_reg  <= '0;
            total_reg  <= '0;
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            scan_reg   <= scan_next;
            rd_vld_reg <= (state_reg == ST_SCAN);
            done_reg   <= emit;
            if (cfg_wr && (paddr[2] == REG_INITIAL_COUNT))
            begin
                init_reg <= pwdata[CountW-1:0];
            end
            if (cfg_wr && (paddr[2] == REG_MAX_COUNT))
            begin
                max_reg <= pwdata[CountW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg;
        if (rd_vld_reg)
        begin
            best_idx_reg  <= cand_idx;
            best_id_reg   <= cand_id;
            best_prio_reg <= cand_prio;
        end
        if (emit)
        begin
            status_reg      <= res_status;
            woken_valid_reg <= res_woke;
            woken_task_reg  <= res_task;
            count_out_reg   <= count_next;
            waiters_out_reg <= WaitersW'(total_next);
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign woken_valid = woken_valid_reg;
    assign woken_task  = woken_task_reg;
    assign count_now   = count_out_reg;
    assign waiters_now = waiters_out_reg;

`ifndef SYNTHESIS
    a_scan_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !done_reg)
        else $error("result strobe during table scan");

    a_woken_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && woken_valid_reg) |-> (status_reg == STAT_WOKE))
        else $error("woken task reported without woke status");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= SlotsTot)
        else $error("waiter total beyond table depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (TotW'(scan_reg) < total_reg))
        else $error("scan index beyond stored waiters");

    a_drain_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (total_reg == TotW'($past(total_reg) - TotW'(1))))
        else $error("wake did not remove exactly one waiter");
`endif

endmodule
